// ===== hdl/fragmenting_stop_and_wait_tx_macros.svh =====
// Assertion macros for the fragmenting stop-and-wait transmitter checks
`ifndef FRAGMENTING_STOP_AND_WAIT_TX_MACROS_SVH
`define FRAGMENTING_STOP_AND_WAIT_TX_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FSWT_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define FSWT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fswt_pkg.sv =====
// Shared types and constants of the fragmenting stop-and-wait transmitter
`timescale 1ns / 1ps
package fswt_pkg;

	localparam int PAYLOAD_W = 12;
	localparam int HEADER_W  = 8;
	localparam int LEN_W     = 13;
	localparam int CNT_W     = 24;
	localparam int RETRY_W   = 16;
	localparam int INDEX_W   = 16;
	localparam int IN_SIZE_W = 16;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [CNT_W-1:0]     CNT_MAX       = 24'hFF_FFFF;
	localparam logic [RETRY_W-1:0]   RETRY_MAX     = 16'hFFFF;
	localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 12'd1024;
	localparam logic [HEADER_W-1:0]  HEADER_RESET  = 8'd20;

	// register index, taken from paddr[2]
	localparam logic REG_PAYLOAD = 1'b0;
	localparam logic REG_HEADER  = 1'b1;

	typedef enum logic [1:0] {
		OP_PACKET = 2'd0,
		OP_ACK    = 2'd1,
		OP_NACK   = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_START,
		ST_FETCH,
		ST_SEND,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/fswt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
module fswt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/fswt_div.sv =====
// Restoring divider: fragment count ceil(size / payload), or one for a zero size, one quotient bit per cycle
`timescale 1ns / 1ps
module fswt_div #(
	parameter int W = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [W-1:0]                   dividend,
	input  logic [fswt_pkg::PAYLOAD_W-1:0] divisor,
	output logic                           done,
	output logic [W-1:0]                   nfrag
);
	import fswt_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0]        cnt_q;
	logic [W-1:0]         quo_q;
	logic [PAYLOAD_W-1:0] rem_q;
	logic [PAYLOAD_W-1:0] dsr_q;
	logic                 zero_q;
	logic [PAYLOAD_W:0]   shifted;
	logic                 fits;

	assign shifted = {rem_q, quo_q[W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			zero_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= CW'(W);
			quo_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
			zero_q <= dividend == '0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			quo_q <= {quo_q[W-2:0], fits};
			if (fits) begin
				rem_q <= PAYLOAD_W'(shifted - {1'b0, dsr_q});
			end else begin
				rem_q <= shifted[PAYLOAD_W-1:0];
			end
		end
	end

	assign done  = cnt_q == '0;
	assign nfrag = zero_q ? W'(1) : quo_q + W'(rem_q != '0);

endmodule

// ===== hdl/fragmenting_stop_and_wait_tx.sv =====
// Top level: fragmenting stop-and-wait transmitter with packet size queue in RAM
`timescale 1ns / 1ps
// Takes one request (packet arrival, ACK or NACK) at a time: start is taken when busy is low,
// and the result appears for exactly one cycle with done high; it cannot be stalled, so capture
// it on that cycle. A NACK goes from accept straight to ST_DONE; an ACK may pass through ST_START,
// ST_FETCH and ST_SEND, and a packet arrival may also pass through ST_DIV before those, because the
// fragment count comes from a divider that produces one quotient bit per cycle. Queued packet sizes
// live in a RAM of QUEUE_DEPTH entries with registered read data; starting a new packet adds the
// ST_FETCH state for that read. No clearing pass after reset. Write the APB registers only while idle.
module fragmenting_stop_and_wait_tx #(
	parameter int QUEUE_DEPTH = 16,
	parameter int SIZE_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fswt_pkg::APB_AW-1:0]    paddr,
	input  logic [fswt_pkg::APB_DW-1:0]    pwdata,
	output logic [fswt_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     op,
	input  logic [fswt_pkg::IN_SIZE_W-1:0] packet_size,
	output logic                           done,
	output logic                           sent,
	output logic [fswt_pkg::INDEX_W-1:0]   fragment_index,
	output logic [fswt_pkg::LEN_W-1:0]     fragment_length,
	output logic                           last_fragment,
	output logic                           resend,
	output logic [fswt_pkg::CNT_W-1:0]     fragments_waiting,
	output logic [fswt_pkg::CNT_W-1:0]     fragments_held,
	output logic                           busy_res,
	output logic                           dropped,
	output logic                           bad_event,
	output logic [fswt_pkg::RETRY_W-1:0]   fragment_retries,
	output logic [fswt_pkg::RETRY_W-1:0]   packet_retries
);
	import fswt_pkg::*;

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int PSW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SEXW = SIZE_BITS > IN_SIZE_W ? SIZE_BITS : IN_SIZE_W;
	localparam int IEXW = SIZE_BITS > INDEX_W ? SIZE_BITS : INDEX_W;
	localparam int HW   = SIZE_BITS > PAYLOAD_W ? SIZE_BITS : PAYLOAD_W;
	localparam int SUMW = (SIZE_BITS > CNT_W ? SIZE_BITS : CNT_W) + 1;

	// config registers
	logic [PAYLOAD_W-1:0] payload_q;
	logic [HEADER_W-1:0]  header_q;
	logic                 cfg_wr;
	logic [PAYLOAD_W-1:0] eff_p;

	// control and state
	state_t               state_q, state_d;
	logic [AW-1:0]        read_slot_q, write_slot_q;
	logic [PSW-1:0]       ps_q;
	logic [SIZE_BITS-1:0] head_q;
	logic [SIZE_BITS-1:0] next_index_q;
	logic                 in_flight_q;
	logic [INDEX_W-1:0]   flight_index_q;
	logic [LEN_W-1:0]     flight_length_q;
	logic                 flight_last_q;
	logic [CNT_W-1:0]     queued_q, held_q;
	logic [RETRY_W-1:0]   frag_retry_q, pkt_retry_q;

	// result registers
	logic                 sent_q, last_q, resend_q, dropped_q, bad_q;
	logic [INDEX_W-1:0]   res_index_q;
	logic [LEN_W-1:0]     res_length_q;
	logic [RETRY_W-1:0]   fr_q, pr_q;

	// datapath
	logic                 full;
	logic                 ram_we, ram_re, div_go, div_done;
	logic [SIZE_BITS-1:0] rd_data, nfrag;
	logic [SEXW-1:0]      size_ext;
	logic [SIZE_BITS-1:0] psize;
	logic [IEXW-1:0]      index_ext;
	logic [INDEX_W-1:0]   cur_index;
	logic [HW-1:0]        head_ext, p_ext, head_rest;
	logic                 more;
	logic [LEN_W-1:0]     full_len, tail_len;
	logic [SUMW-1:0]      queued_sum, held_sum;
	logic [AW-1:0]        write_slot_inc, read_slot_inc;
	logic                 ack_ok, nack_ok, idle_event, drop_now;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= PAYLOAD_RESET;
			header_q  <= HEADER_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PAYLOAD: payload_q <= pwdata[PAYLOAD_W-1:0];
				REG_HEADER:  header_q  <= pwdata[HEADER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PAYLOAD: prdata = APB_DW'(payload_q);
			REG_HEADER:  prdata = APB_DW'(header_q);
			default:     prdata = '0;
		endcase
	end

	assign eff_p = (payload_q == '0) ? PAYLOAD_W'(1) : payload_q;

	// datapath helpers
	assign size_ext  = SEXW'(packet_size);
	assign psize     = size_ext[SIZE_BITS-1:0];
	assign full      = ps_q == PSW'(QUEUE_DEPTH);
	assign index_ext = IEXW'(next_index_q);
	assign cur_index = index_ext[INDEX_W-1:0];
	assign head_ext  = HW'(head_q);
	assign p_ext     = HW'(eff_p);
	assign more      = head_ext > p_ext;
	assign head_rest = head_ext - p_ext;
	assign full_len  = LEN_W'(eff_p) + LEN_W'(header_q);
	assign tail_len  = LEN_W'(head_ext[PAYLOAD_W-1:0]) + LEN_W'(header_q);
	assign queued_sum = SUMW'(queued_q) + SUMW'(nfrag);
	assign held_sum   = SUMW'(held_q) + SUMW'(nfrag);
	assign write_slot_inc = (write_slot_q == AW'(QUEUE_DEPTH - 1)) ? '0 : write_slot_q + 1'b1;
	assign read_slot_inc  = (read_slot_q == AW'(QUEUE_DEPTH - 1)) ? '0 : read_slot_q + 1'b1;

	// request decode
	assign ack_ok     = op_t'(op) == OP_ACK && in_flight_q;
	assign nack_ok    = op_t'(op) == OP_NACK && in_flight_q;
	assign idle_event = (op_t'(op) inside {OP_ACK, OP_NACK}) && !in_flight_q;
	assign drop_now   = op_t'(op) == OP_PACKET && full;

	fswt_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_size_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (write_slot_q),
		.wdata (psize),
		.re    (ram_re),
		.raddr (read_slot_q),
		.rdata (rd_data)
	);

	fswt_div #(
		.W (SIZE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (psize),
		.divisor  (eff_p),
		.done     (div_done),
		.nfrag    (nfrag)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op_t'(op))
						OP_PACKET: state_d = full ? ST_START : ST_DIV;
						OP_ACK:    state_d = in_flight_q ? ST_START : ST_DONE;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (!in_flight_q && ps_q != '0) begin
					state_d = (next_index_q == '0) ? ST_FETCH : ST_SEND;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FETCH: state_d = ST_SEND;
			ST_SEND:  state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy   = state_q != ST_IDLE;
		done   = state_q == ST_DONE;
		ram_re = state_q == ST_START;
		div_go = state_q == ST_IDLE && start && op_t'(op) == OP_PACKET && !full;
		ram_we = div_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			read_slot_q     <= '0;
			write_slot_q    <= '0;
			ps_q            <= '0;
			head_q          <= '0;
			next_index_q    <= '0;
			in_flight_q     <= 1'b0;
			flight_index_q  <= '0;
			flight_length_q <= '0;
			flight_last_q   <= 1'b0;
			queued_q        <= '0;
			held_q          <= '0;
			frag_retry_q    <= '0;
			pkt_retry_q     <= '0;
			sent_q          <= 1'b0;
			last_q          <= 1'b0;
			resend_q        <= 1'b0;
			dropped_q       <= 1'b0;
			bad_q           <= 1'b0;
			res_index_q     <= '0;
			res_length_q    <= '0;
			fr_q            <= '0;
			pr_q            <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						sent_q       <= nack_ok;
						resend_q     <= nack_ok;
						last_q       <= nack_ok && flight_last_q;
						res_index_q  <= nack_ok ? flight_index_q : '0;
						res_length_q <= nack_ok ? flight_length_q : '0;
						dropped_q    <= drop_now;
						bad_q        <= idle_event;
						fr_q         <= ack_ok ? frag_retry_q : '0;
						pr_q         <= (ack_ok && flight_last_q) ? pkt_retry_q : '0;
						case (op_t'(op))
							OP_PACKET: begin
								if (!full) begin
									write_slot_q <= write_slot_inc;
									ps_q         <= ps_q + 1'b1;
								end
							end
							OP_ACK: begin
								if (in_flight_q) begin
									frag_retry_q <= '0;
									if (flight_last_q) begin
										pkt_retry_q <= '0;
									end
									if (held_q != '0) begin
										held_q <= held_q - 1'b1;
									end
									in_flight_q <= 1'b0;
								end
							end
							OP_NACK: begin
								if (in_flight_q) begin
									if (frag_retry_q != RETRY_MAX) begin
										frag_retry_q <= frag_retry_q + 1'b1;
									end
									if (pkt_retry_q != RETRY_MAX) begin
										pkt_retry_q <= pkt_retry_q + 1'b1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						queued_q <= (queued_sum > SUMW'(CNT_MAX)) ? CNT_MAX : queued_sum[CNT_W-1:0];
						held_q   <= (held_sum > SUMW'(CNT_MAX)) ? CNT_MAX : held_sum[CNT_W-1:0];
					end
				end
				ST_FETCH: begin
					head_q <= rd_data;
				end
				ST_SEND: begin
					flight_index_q <= cur_index;
					res_index_q    <= cur_index;
					sent_q         <= 1'b1;
					in_flight_q    <= 1'b1;
					if (queued_q != '0) begin
						queued_q <= queued_q - 1'b1;
					end
					if (more) begin
						flight_length_q <= full_len;
						res_length_q    <= full_len;
						flight_last_q   <= 1'b0;
						last_q          <= 1'b0;
						head_q          <= head_rest[SIZE_BITS-1:0];
						next_index_q    <= next_index_q + 1'b1;
					end else begin
						flight_length_q <= tail_len;
						res_length_q    <= tail_len;
						flight_last_q   <= 1'b1;
						last_q          <= 1'b1;
						head_q          <= '0;
						next_index_q    <= '0;
						read_slot_q     <= read_slot_inc;
						if (ps_q != '0) begin
							ps_q <= ps_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign sent              = sent_q;
	assign fragment_index    = res_index_q;
	assign fragment_length   = res_length_q;
	assign last_fragment     = last_q;
	assign resend            = resend_q;
	assign fragments_waiting = queued_q;
	assign fragments_held    = held_q;
	assign busy_res          = in_flight_q;
	assign dropped           = dropped_q;
	assign bad_event         = bad_q;
	assign fragment_retries  = fr_q;
	assign packet_retries    = pr_q;

endmodule

// ===== hdl/fswt_chk.sv =====
// Port-level checks of the fragmenting stop-and-wait transmitter, bound to the top level
`timescale 1ns / 1ps
`include "fragmenting_stop_and_wait_tx_macros.svh"
module fswt_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         sent,
	input logic                         resend,
	input logic                         dropped,
	input logic                         bad_event,
	input logic [fswt_pkg::RETRY_W-1:0] fragment_retries,
	input logic [fswt_pkg::RETRY_W-1:0] packet_retries
);

	`FSWT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`FSWT_ASSERT_NEXT(a_done_single, done, !done && !busy, "done not a single-cycle end of request")
	`FSWT_ASSERT_IMPL(a_resend_clean, done && resend, sent && !dropped && !bad_event && fragment_retries == '0, "resend result inconsistent")
	`FSWT_ASSERT_IMPL(a_bad_quiet, done && bad_event, !sent && fragment_retries == '0 && packet_retries == '0, "bad event reported activity")

endmodule

bind fragmenting_stop_and_wait_tx fswt_chk u_fswt_chk (.*);

// ===== tb/sv/tb_fragmenting_stop_and_wait_tx.sv =====
// Testbench: directed and random requests with a fragment-tracking scoreboard and APB checks
`timescale 1ns / 1ps
module tb_fragmenting_stop_and_wait_tx;
	import fswt_pkg::*;

	localparam int DEPTH         = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 25;
	localparam int PHASE_ITEMS   = 68;
	localparam int MAX_PRINTS    = 40;

	typedef struct packed {
		logic                 sent;
		logic [INDEX_W-1:0]   frag_index;
		logic [LEN_W-1:0]     frag_len;
		logic                 last;
		logic                 resend;
		logic [CNT_W-1:0]     waiting;
		logic [CNT_W-1:0]     held;
		logic                 busy_res;
		logic                 dropped;
		logic                 bad;
		logic [RETRY_W-1:0]   frag_retries;
		logic [RETRY_W-1:0]   pkt_retries;
	} tx_report_t;

	class arq_tracker;
		logic [PAYLOAD_W-1:0]   payload_reg = PAYLOAD_RESET;
		logic [HEADER_W-1:0]    header_reg  = HEADER_RESET;
		logic [IN_SIZE_W-1:0]   size_q[DEPTH];
		int unsigned            rd_slot, wr_slot, stored, head_left;
		logic [INDEX_W-1:0]     next_idx, fl_idx;
		int unsigned            fl_len, queued, held;
		bit                     flying, fl_last;
		int unsigned            frag_nacks, pkt_nacks;
		tx_report_t             pending_reports[$];
		int                     mismatch_count, results_seen;
		int                     requests, sends, resends, drops, bad_events;

		function int unsigned eff_payload();
			return (payload_reg == 0) ? 1 : payload_reg;
		endfunction

		function int unsigned sat_cnt(longint unsigned v);
			return (v > CNT_MAX) ? 32'(CNT_MAX) : 32'(v);
		endfunction

		function int unsigned sat_dec(int unsigned v);
			return (v == 0) ? 0 : v - 1;
		endfunction

		function void start_next();
			int unsigned p;
			p = eff_payload();
			if (next_idx == 0)
				head_left = size_q[rd_slot];
			fl_idx = next_idx;
			if (head_left > p) begin
				fl_len = p + header_reg;
				fl_last = 0;
				head_left -= p;
				next_idx = next_idx + 1'b1;
			end else begin
				fl_len = head_left + header_reg;
				fl_last = 1;
				head_left = 0;
				next_idx = 0;
				rd_slot = (rd_slot + 1) % DEPTH;
				stored = sat_dec(stored);
			end
			flying = 1;
			queued = sat_dec(queued);
		endfunction

		function void note_request(op_t code, logic [IN_SIZE_W-1:0] size);
			tx_report_t r;
			int unsigned p, nfrag;
			r = '0;
			case (code)
				OP_PACKET: begin
					if (stored >= DEPTH) begin
						r.dropped = 1;
					end else begin
						p = eff_payload();
						nfrag = (size == 0) ? 1 : (size + p - 1) / p;
						size_q[wr_slot] = size;
						wr_slot = (wr_slot + 1) % DEPTH;
						stored++;
						queued = sat_cnt(longint'(queued) + nfrag);
						held = sat_cnt(longint'(held) + nfrag);
					end
					if (!flying && stored > 0) begin
						start_next();
						r.sent = 1;
					end
				end
				OP_ACK: begin
					if (!flying) begin
						r.bad = 1;
					end else begin
						r.frag_retries = RETRY_W'(frag_nacks);
						frag_nacks = 0;
						if (fl_last) begin
							r.pkt_retries = RETRY_W'(pkt_nacks);
							pkt_nacks = 0;
						end
						held = sat_dec(held);
						flying = 0;
						if (stored > 0) begin
							start_next();
							r.sent = 1;
						end
					end
				end
				OP_NACK: begin
					if (!flying) begin
						r.bad = 1;
					end else begin
						if (frag_nacks < RETRY_MAX) frag_nacks++;
						if (pkt_nacks < RETRY_MAX) pkt_nacks++;
						r.sent = 1;
						r.resend = 1;
					end
				end
				default: ;
			endcase
			if (r.sent) begin
				r.frag_index = fl_idx;
				r.frag_len = LEN_W'(fl_len);
				r.last = fl_last;
			end
			r.waiting = CNT_W'(queued);
			r.held = CNT_W'(held);
			r.busy_res = flying;
			pending_reports.push_back(r);
			requests++;
			sends += r.sent;
			resends += r.resend;
			drops += r.dropped;
			bad_events += r.bad;
		endfunction

		task flag_mismatch(string msg);
			mismatch_count++;
			if (mismatch_count <= MAX_PRINTS)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		task cmp(string field, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
			if (got !== want)
				flag_mismatch($sformatf("result %0d %s: got %0d expected %0d",
					results_seen, field, got, want));
		endtask

		task check_report(tx_report_t got);
			tx_report_t want;
			results_seen++;
			if (pending_reports.size() == 0) begin
				flag_mismatch($sformatf("result %0d with no request pending", results_seen));
				return;
			end
			want = pending_reports.pop_front();
			cmp("sent", got.sent, want.sent);
			cmp("fragment_index", got.frag_index, want.frag_index);
			cmp("fragment_length", got.frag_len, want.frag_len);
			cmp("last_fragment", got.last, want.last);
			cmp("resend", got.resend, want.resend);
			cmp("fragments_waiting", got.waiting, want.waiting);
			cmp("fragments_held", got.held, want.held);
			cmp("busy_res", got.busy_res, want.busy_res);
			cmp("dropped", got.dropped, want.dropped);
			cmp("bad_event", got.bad, want.bad);
			cmp("fragment_retries", got.frag_retries, want.frag_retries);
			cmp("packet_retries", got.pkt_retries, want.pkt_retries);
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   psel, penable, pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   start;
	logic                   busy;
	logic [1:0]             op;
	logic [IN_SIZE_W-1:0]   packet_size;
	logic                   done;
	logic                   sent;
	logic [INDEX_W-1:0]     fragment_index;
	logic [LEN_W-1:0]       fragment_length;
	logic                   last_fragment;
	logic                   resend;
	logic [CNT_W-1:0]       fragments_waiting;
	logic [CNT_W-1:0]       fragments_held;
	logic                   busy_res;
	logic                   dropped;
	logic                   bad_event;
	logic [RETRY_W-1:0]     fragment_retries;
	logic [RETRY_W-1:0]     packet_retries;

	arq_tracker tracker = new();
	int         cycle_count = 0;
	bit         no_idle = 0;
	int         settings_used = 1;

	fragmenting_stop_and_wait_tx uut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, tracker.pending_reports.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_report({sent, fragment_index, fragment_length, last_fragment, resend,
				fragments_waiting, fragments_held, busy_res, dropped, bad_event,
				fragment_retries, packet_retries});
	end

	task automatic send_request(op_t code, logic [IN_SIZE_W-1:0] size);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= code;
		packet_size <= size;
		do @(posedge clk); while (busy);
		tracker.note_request(code, size);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (tracker.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic reg_sel, logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_PAYLOAD)
			tracker.payload_reg = value[PAYLOAD_W-1:0];
		else
			tracker.header_reg = value[HEADER_W-1:0];
		@(posedge clk);
	endtask

	task automatic apb_read_check(logic reg_sel);
		logic [APB_DW-1:0] want;
		want = (reg_sel == REG_PAYLOAD) ? APB_DW'(tracker.payload_reg)
			: APB_DW'(tracker.header_reg);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			tracker.flag_mismatch($sformatf("register %0d read %0d expected %0d",
				reg_sel, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int unsigned pay, int unsigned hdr);
		wait_drained();
		apb_write(REG_PAYLOAD, {$urandom} << PAYLOAD_W | pay);
		apb_write(REG_HEADER, {$urandom} << HEADER_W | hdr);
		apb_read_check(REG_PAYLOAD);
		apb_read_check(REG_HEADER);
		settings_used++;
	endtask

	function automatic logic [IN_SIZE_W-1:0] pick_size();
		int unsigned p, v;
		p = tracker.eff_payload();
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 65535);
			1: v = 0;
			2: v = p * $urandom_range(1, 4);
			default: v = $urandom_range(1, 3 * p);
		endcase
		return (v > 65535) ? 16'hFFFF : v[IN_SIZE_W-1:0];
	endfunction

	task automatic random_phase(int items);
		int counted, arrive_pct, r;
		op_t code;
		counted = 0;
		arrive_pct = $urandom_range(10, 60);
		no_idle = ($urandom_range(0, 3) == 0);
		while (counted < items) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				code = OP_SPARE;
			else if (!tracker.flying)
				code = (r < 88) ? OP_PACKET : (r < 94) ? OP_ACK : OP_NACK;
			else
				code = (r < 3 + arrive_pct) ? OP_PACKET
					: (r < 18 + arrive_pct) ? OP_NACK : OP_ACK;
			if ($urandom_range(0, 19) == 0)
				no_idle = !no_idle;
			send_request(code, (code == OP_PACKET) ? pick_size() : 16'($urandom));
			if (code != OP_SPARE)
				counted++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		op <= OP_PACKET;
		packet_size <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read_check(REG_PAYLOAD);
		apb_read_check(REG_HEADER);

		// idle events, empty packet with retries, long packet, then fill the queue to overflow
		send_request(OP_ACK, 16'h0000);
		send_request(OP_NACK, 16'hFFFF);
		send_request(OP_SPARE, 16'h5A5A);
		send_request(OP_PACKET, 16'h0000);
		send_request(OP_NACK, 16'h0000);
		send_request(OP_NACK, 16'h0000);
		send_request(OP_ACK, 16'h0000);
		send_request(OP_PACKET, 16'hFFFF);
		send_request(OP_SPARE, 16'hA5A5);
		send_request(OP_PACKET, 16'd1024);
		send_request(OP_PACKET, 16'd1025);
		for (int k = 0; k < 14; k++)
			send_request(OP_PACKET, (k % 2) ? 16'd1 : 16'($urandom_range(1000, 5000)));

		random_phase(PHASE_ITEMS);
		configure(0, 0);
		random_phase(PHASE_ITEMS);
		configure(1, 255);
		random_phase(PHASE_ITEMS);
		configure(4095, 255);
		random_phase(PHASE_ITEMS);
		configure(4095, 0);
		random_phase(PHASE_ITEMS);
		configure($urandom_range(2, 64), $urandom_range(0, 255));
		random_phase(PHASE_ITEMS);
		configure($urandom_range(1, 4095), $urandom_range(0, 255));
		random_phase(PHASE_ITEMS);

		wait_drained();
		$display("Run covered %0d requests under %0d register settings: %0d sends, %0d resends,",
			tracker.requests, settings_used, tracker.sends, tracker.resends);
		$display("%0d drops, %0d bad events; %0d results checked, %0d mismatches",
			tracker.drops, tracker.bad_events, tracker.results_seen, tracker.mismatch_count);
		if (tracker.mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== fragmenting_stop_and_wait_tx.f =====
+incdir+hdl
hdl/fswt_pkg.sv
hdl/fswt_ram.sv
hdl/fswt_div.sv
hdl/fragmenting_stop_and_wait_tx.sv
hdl/fswt_chk.sv
tb/sv/tb_fragmenting_stop_and_wait_tx.sv
